// File: hw/rtl/pvi_pkg.sv
// shared types and constants for the poisson variate by inversion block
// no dependencies; used by pvi_divider, poisson_variate_by_inversion and the bench
package pvi_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 40;
  localparam int PROB_W     = FRAC_W + 1;
  localparam int MEAN_FRAC  = 24;
  localparam int MUL_B_W    = 24;
  localparam int MUL_W      = WORD_W + MUL_B_W;
  localparam int DIVIDEND_W = 50;
  localparam int DIV_STEPS  = DIVIDEND_W / 2;
  localparam int OUT_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [PROB_W-1:0] P_CLAMP = PROB_W'(1) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PROB = 1'b1;

  localparam logic [WORD_W-1:0] MEAN_RATE_RESET  = 32'd16777216;
  localparam logic [WORD_W-1:0] START_PROB_RESET = 32'd1580030169;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/pvi_divider.sv
// iterative restoring divider, two quotient bits per cycle
// depends on pvi_pkg for the dividend width and step count
module pvi_divider #(
  parameter int DIVISOR_W = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [pvi_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0]              divisor,
  output logic                              done,
  output logic [pvi_pkg::DIVIDEND_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(pvi_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pvi_pkg::DIV_STEPS - 1);

  logic                           busy;
  logic [CNT_W-1:0]               step;
  logic [pvi_pkg::DIVIDEND_W-1:0] work;
  logic [DIVISOR_W-1:0]           rem;
  logic [DIVISOR_W-1:0]           dvs;

  logic [DIVISOR_W:0]             t1, t2;
  logic                           ge1, ge2;
  logic [DIVISOR_W-1:0]           rem1, rem2;
  logic [pvi_pkg::DIVIDEND_W-1:0] work1, work2;

  // two dependent shift-compare-subtract steps
  always_comb begin
    t1    = {rem, work[pvi_pkg::DIVIDEND_W-1]};
    ge1   = t1 >= {1'b0, dvs};
    rem1  = ge1 ? DIVISOR_W'(t1 - {1'b0, dvs}) : t1[DIVISOR_W-1:0];
    work1 = {work[pvi_pkg::DIVIDEND_W-2:0], ge1};
    t2    = {rem1, work1[pvi_pkg::DIVIDEND_W-1]};
    ge2   = t2 >= {1'b0, dvs};
    rem2  = ge2 ? DIVISOR_W'(t2 - {1'b0, dvs}) : t2[DIVISOR_W-1:0];
    work2 = {work1[pvi_pkg::DIVIDEND_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= work2;
      rem  <= rem2;
    end
  end

  assign quotient = work;

endmodule

// File: hw/rtl/poisson_variate_by_inversion.sv
// poisson variate by inversion: one uniform word in, one count out
// sequence: the accepted word is loaded, then each iteration runs a compare/subtract
//   step, two shared multiply passes (low then high bits of p) and a divide by
//   count in the two-bit-per-cycle divider, until the loop stops and the result is offered
// throughput: one word at a time, next word taken after the result is taken
// reset: synchronous rst returns the sequencer to idle, configuration registers to defaults
module poisson_variate_by_inversion #(
  parameter int MAX_COUNT = 255
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // [31:0] uniform_word
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] event_count
  output logic                              m_axis_tuser,  // [0] count_saturated
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pvi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int COUNT_W = $clog2(MAX_COUNT + 1);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_COUNT);

  // configuration registers
  logic [pvi_pkg::WORD_W-1:0] mean_rate;
  logic [pvi_pkg::WORD_W-1:0] start_probability;

  // sequencer
  pvi_pkg::state_t state, state_next;

  // datapath registers: residual u, running probability p, count, partial product
  logic [pvi_pkg::FRAC_W-1:0] u;
  logic [pvi_pkg::PROB_W-1:0] p;
  logic [COUNT_W-1:0]         count;
  logic [pvi_pkg::WORD_W-1:0] acc;

  logic                           keep_going;
  logic [pvi_pkg::MUL_B_W-1:0]    mul_b;
  logic [pvi_pkg::MUL_W-1:0]      mul_prod;
  logic [pvi_pkg::DIVIDEND_W-1:0] div_dividend;
  logic                           div_start;
  logic                           div_done;
  logic [pvi_pkg::DIVIDEND_W-1:0] div_quotient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_rate         <= pvi_pkg::MEAN_RATE_RESET;
      start_probability <= pvi_pkg::START_PROB_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pvi_pkg::REG_MEAN_RATE:  mean_rate         <= cfg_data;
        pvi_pkg::REG_START_PROB: start_probability <= cfg_data;
        default: ;
      endcase
    end
  end

  // loop continues while u > p and the count limit is not reached
  assign keep_going = ({1'b0, u} > p) && (count < COUNT_LIMIT);

  // shared multiplier: low 24 bits of p first, then the high bits
  assign mul_b    = (state == pvi_pkg::ST_MUL_LO) ? p[pvi_pkg::MEAN_FRAC-1:0]
                  : pvi_pkg::MUL_B_W'(p[pvi_pkg::PROB_W-1:pvi_pkg::MEAN_FRAC]);
  assign mul_prod = pvi_pkg::MUL_W'(mean_rate) * pvi_pkg::MUL_W'(mul_b);

  // floor(mean * p / 2^24) = mean * p_hi + floor(mean * p_lo / 2^24)
  assign div_dividend = pvi_pkg::DIVIDEND_W'(mul_prod) + pvi_pkg::DIVIDEND_W'(acc);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pvi_pkg::ST_IDLE:   if (s_axis_tvalid) state_next = pvi_pkg::ST_CHECK;
      pvi_pkg::ST_CHECK:  state_next = keep_going ? pvi_pkg::ST_MUL_LO : pvi_pkg::ST_DONE;
      pvi_pkg::ST_MUL_LO: state_next = pvi_pkg::ST_MUL_HI;
      pvi_pkg::ST_MUL_HI: state_next = pvi_pkg::ST_DIVIDE;
      pvi_pkg::ST_DIVIDE: if (div_done) state_next = pvi_pkg::ST_CHECK;
      pvi_pkg::ST_DONE:   if (m_axis_tready) state_next = pvi_pkg::ST_IDLE;
      default:            state_next = pvi_pkg::ST_IDLE;
    endcase
  end

  // handshake and unit controls
  always_comb begin
    s_axis_tready = (state == pvi_pkg::ST_IDLE);
    m_axis_tvalid = (state == pvi_pkg::ST_DONE);
    div_start     = (state == pvi_pkg::ST_MUL_HI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pvi_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          u     <= {s_axis_tdata, 8'b0};
          p     <= {1'b0, start_probability, 8'b0};
          count <= '0;
        end
      end
      pvi_pkg::ST_CHECK: begin
        if (keep_going) begin
          u     <= pvi_pkg::FRAC_W'({1'b0, u} - p);
          count <= count + COUNT_W'(1);
        end
      end
      pvi_pkg::ST_MUL_LO: begin
        acc <= mul_prod[pvi_pkg::MUL_W-1:pvi_pkg::MEAN_FRAC];
      end
      pvi_pkg::ST_DIVIDE: begin
        // clamp the new probability to 1.0
        if (div_done) begin
          if (div_quotient > pvi_pkg::DIVIDEND_W'(pvi_pkg::P_CLAMP)) begin
            p <= pvi_pkg::P_CLAMP;
          end else begin
            p <= div_quotient[pvi_pkg::PROB_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  pvi_divider #(
    .DIVISOR_W(COUNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // result word: count truncated to 8 bits, flag when the limit was reached
  assign m_axis_tdata = pvi_pkg::OUT_W'(count);
  assign m_axis_tuser = (count >= COUNT_LIMIT);

endmodule

// File: bench/pvi_checker.sv
// draw checker for poisson_variate_by_inversion: mirrors the registers, predicts each count
// depends on pvi_pkg; watches the stream and register write channels
module pvi_checker #(
  parameter int MAX_COUNT = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [pvi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int          outstanding,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROD_W = pvi_pkg::WORD_W + pvi_pkg::PROB_W;

  typedef struct packed {
    logic [7:0] event_count;
    logic       count_saturated;
  } draw_t;

  logic [31:0] mean_q  = pvi_pkg::MEAN_RATE_RESET;
  logic [31:0] start_q = pvi_pkg::START_PROB_RESET;
  draw_t       pending_draws[$];

  // sequential inversion in UQ.40, truncating at every step
  function automatic draw_t draw_count(input logic [31:0] word, input logic [31:0] mean,
                                       input logic [31:0] start);
    logic [pvi_pkg::PROB_W-1:0] u;
    logic [pvi_pkg::PROB_W-1:0] p;
    logic [PROD_W-1:0]          scaled;
    int unsigned                n;
    draw_t                      d;
    u = {1'b0, word, 8'h00};
    p = {1'b0, start, 8'h00};
    n = 0;
    while (u > p && n < MAX_COUNT) begin
      u = u - p;
      n = n + 1;
      scaled = (PROD_W'(mean) * PROD_W'(p)) >> pvi_pkg::MEAN_FRAC;
      scaled = scaled / PROD_W'(n);
      p = (scaled > PROD_W'(pvi_pkg::P_CLAMP)) ? pvi_pkg::P_CLAMP
                                               : scaled[pvi_pkg::PROB_W-1:0];
    end
    d.event_count     = n[7:0];
    d.count_saturated = (n >= MAX_COUNT);
    return d;
  endfunction

  always @(posedge clk) begin
    draw_t want;
    draw_t got;
    int    bad;
    bad = 0;
    if (rst) begin
      mean_q      <= pvi_pkg::MEAN_RATE_RESET;
      start_q     <= pvi_pkg::START_PROB_RESET;
      outstanding <= 0;
      mismatches  <= 0;
      pending_draws.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pvi_pkg::REG_MEAN_RATE) mean_q <= cfg_data;
        else if (cfg_index == pvi_pkg::REG_START_PROB) start_q <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_draws.push_back(draw_count(s_axis_tdata, mean_q, start_q));
      if (m_axis_tvalid && m_axis_tready) begin
        got.event_count     = m_axis_tdata;
        got.count_saturated = m_axis_tuser;
        if (pending_draws.size() == 0) begin
          $display("%0t: unexpected result count=%0d sat=%0b", $time,
                   got.event_count, got.count_saturated);
          bad = bad + 1;
        end else begin
          want = pending_draws.pop_front();
          if (got.event_count !== want.event_count) begin
            $display("%0t: event_count expected %0d actual %0d", $time,
                     want.event_count, got.event_count);
            bad = bad + 1;
          end
          if (got.count_saturated !== want.count_saturated) begin
            $display("%0t: count_saturated expected %0b actual %0b", $time,
                     want.count_saturated, got.count_saturated);
            bad = bad + 1;
          end
        end
      end
      outstanding <= pending_draws.size();
      mismatches  <= mismatches + bad;
    end
  end

endmodule

// File: bench/tb_poisson_variate_by_inversion.sv
// top of the poisson_variate_by_inversion bench: clock, reset, stimulus and verdict
// depends on pvi_pkg, poisson_variate_by_inversion and pvi_checker
module tb_poisson_variate_by_inversion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COUNT   = 255;
  // watchdog limit, set with a wide margin over the slowest run of this stimulus
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 240;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;          // [31:0] uniform_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;               // [7:0] event_count
  logic        m_axis_tuser;               // [0] count_saturated
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [pvi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int          outstanding;
  int          mismatches;
  int          cycles = 0;
  int          stall_left = 0;
  logic        source_steady = 1'b0;
  logic        sink_steady = 1'b0;
  logic [31:0] cur_start = pvi_pkg::START_PROB_RESET;

  always #2 clk = ~clk;

  poisson_variate_by_inversion #(.MAX_COUNT(MAX_COUNT)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pvi_checker #(.MAX_COUNT(MAX_COUNT)) u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result sink: mostly ready, short stalls, now and then a long one; no new stalls while sink_steady is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_steady || $urandom_range(0, 3) != 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3);
    end
  end

  // idle cycles before a word: half none, most short, a few long; none while source_steady is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (source_steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // exp(-mean) as UQ0.32, held inside the legal register range
  function automatic logic [31:0] start_for_mean(input logic [31:0] mean);
    real x;
    x = $exp(-(real'(mean) / 16777216.0)) * 4294967296.0;
    if (x >= 4294967295.0) return 32'hFFFF_FFFF;
    if (x < 1.0) return 32'd1;
    return 32'(longint'($floor(x)));
  endfunction

  // leaves tvalid high so back-to-back words need no second assignment
  task automatic send_word(input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [pvi_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // block must be idle: every word sent so far has its result back
  task automatic program_draw(input logic [31:0] mean, input logic [31:0] start);
    drain();
    if ($urandom_range(0, 1)) begin
      write_reg(pvi_pkg::REG_MEAN_RATE, mean);
      write_reg(pvi_pkg::REG_START_PROB, start);
    end else begin
      write_reg(pvi_pkg::REG_START_PROB, start);
      write_reg(pvi_pkg::REG_MEAN_RATE, mean);
    end
    cfg_valid <= 1'b0;
    cur_start = start;
  endtask

  // random word with an occasional pick of zero, all ones or the boundary against the start probability
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return cur_start;
      3:       return cur_start + 32'd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] mean;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: mean 1.0, boundaries of u against the start probability
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    send_word(pvi_pkg::START_PROB_RESET);
    send_word(pvi_pkg::START_PROB_RESET + 32'd1);

    // zero mean: p drops to zero after one step, so any leftover u saturates
    program_draw(32'd0, 32'h8000_0000);
    send_word(32'h8000_0001);
    send_word(32'h8000_0000);
    send_word(32'hFFFF_FFFF);

    // smallest start probability: p vanishes, long run up to the count limit
    program_draw(pvi_pkg::MEAN_RATE_RESET, 32'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'd0);
    send_word(32'd2);

    // largest mean with a tiny start: p overshoots one and gets clamped
    program_draw(32'hFFFF_FFFF, 32'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'h1234_5678);

    // both registers at their top value
    program_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE);

    // main random part: matched settings, small to moderate means
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mean = (ph == 0) ? 32'd0 : $urandom_range(0, 32'd134217728);
      program_draw(mean, start_for_mean(mean));
      source_steady <= (ph == 2);
      sink_steady   <= (ph == 2) || (ph == 5);
      repeat (PHASE_WORDS) send_word(pick_word());
    end
    source_steady <= 1'b0;
    sink_steady   <= 1'b0;

    // mismatched registers with every bit free; runs may be long, so keep them few
    for (int ph = 0; ph < 3; ph++) begin
      program_draw($urandom, $urandom_range(1, 32'hFFFF_FFFF));
      repeat (4) send_word(pick_word());
    end

    // large means: exp underflows to the minimum start, counts get big
    mean = $urandom_range(32'h2000_0000, 32'hFFFF_FFFF);
    program_draw(mean, start_for_mean(mean));
    repeat (8) send_word(pick_word());

    drain();
    // room for any stray result after the last expected one
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
